>>> rtl/core/dhp_pkg.sv
// Drum hit pacer package: FIFO sizing, register reset values, register
// indexes and the FIFO status struct. No dependencies.
package dhp_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int LANE_W  = 3;
    localparam int VALUE_W = 16;
    localparam int CIDX_W  = 8;

    localparam logic [VALUE_W-1:0] ANALOG_THRESHOLD = 16'd100;
    localparam logic [VALUE_W-1:0] RESET_COOLDOWN   = 16'd4;
    localparam logic [VALUE_W-1:0] RESET_FLOOR      = 16'd15000;
    localparam logic [VALUE_W-1:0] RESET_CEILING    = 16'd30000;

    localparam logic [CIDX_W-1:0] CFG_ANALOG_MODE = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_COOLDOWN    = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_HIT_FLOOR   = 8'd2;
    localparam logic [CIDX_W-1:0] CFG_HIT_CEILING = 8'd3;

    typedef struct packed {
        logic [LANE_W-1:0] front;
        logic              empty;
        logic              full;
    } t_fifo_status;

endpackage

>>> rtl/core/dhp_fifo.sv
// Per-player pending tap FIFO: lane numbers, head pointer and fill count.
// Depends on dhp_pkg.
module dhp_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_pop,
    input  logic [dhp_pkg::LANE_W-1:0]    i_lane,
    output dhp_pkg::t_fifo_status         o_status
);

    logic [dhp_pkg::LANE_W-1:0] r_mem [dhp_pkg::FIFO_DEPTH];
    logic [dhp_pkg::LANE_W-1:0] r_front;
    logic [dhp_pkg::PTR_W-1:0]  r_head;
    logic [dhp_pkg::CNT_W-1:0]  r_count;
    logic [dhp_pkg::PTR_W-1:0]  n_head;
    logic [dhp_pkg::CNT_W-1:0]  n_count;
    logic [dhp_pkg::CNT_W:0]    tail_sum;
    logic [dhp_pkg::PTR_W-1:0]  tail;
    logic                       do_push;
    logic                       do_pop;

    assign o_status.front = r_front;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == dhp_pkg::CNT_W'(dhp_pkg::FIFO_DEPTH));

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        tail_sum = {1'b0, r_count} + (dhp_pkg::CNT_W+1)'(r_head);
        if (tail_sum >= (dhp_pkg::CNT_W+1)'(dhp_pkg::FIFO_DEPTH)) begin
            tail_sum = tail_sum - (dhp_pkg::CNT_W+1)'(dhp_pkg::FIFO_DEPTH);
        end
        tail = tail_sum[dhp_pkg::PTR_W-1:0];

        n_head = r_head;
        if (do_pop) begin
            if (r_head == dhp_pkg::PTR_W'(dhp_pkg::FIFO_DEPTH - 1)) begin
                n_head = '0;
            end else begin
                n_head = r_head + 1'b1;
            end
        end

        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // front word kept in a register; only meaningful while not empty
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[tail] <= i_lane;
        end
        if (do_pop) begin
            r_front <= (r_count == dhp_pkg::CNT_W'(1)) ? i_lane : r_mem[n_head];
        end else if (do_push && o_status.empty) begin
            r_front <= i_lane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/drum_hit_pacer_top.sv
// Drum hit pacer top level: input register, hit pacing logic, result register.
// Depends on dhp_pkg and dhp_fifo.
//
// Each accepted poll word yields exactly one result word via the input register
// and then the result register; a new poll is taken every cycle, limited
// only by downstream tready through the single input and result registers.
// Configuration writes are always accepted (o_cfg_ready is tied high) and
// take effect on the next poll. Reset needs no clearing pass.
module drum_hit_pacer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // lane[2:0], tapped[3], axis_level[19:4], zero[23:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // level[15:0], tap_dropped[16], zero[23:17]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dhp_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [dhp_pkg::VALUE_W-1:0] i_cfg_data
);

    logic                        r_analog_mode;
    logic [dhp_pkg::VALUE_W-1:0] r_cool_period;
    logic [dhp_pkg::VALUE_W-1:0] r_hit_floor;
    logic [dhp_pkg::VALUE_W-1:0] r_hit_ceiling;

    logic                        r_in_valid;
    logic [dhp_pkg::LANE_W-1:0]  r_lane;
    logic                        r_tapped;
    logic [dhp_pkg::VALUE_W-1:0] r_axis;

    logic                        r_out_valid;
    logic [dhp_pkg::VALUE_W-1:0] r_level;
    logic                        r_dropped;

    logic [dhp_pkg::VALUE_W-1:0] r_rolling;
    logic [dhp_pkg::VALUE_W-1:0] r_cool_one;
    logic [dhp_pkg::VALUE_W-1:0] r_cool_two;

    logic [dhp_pkg::VALUE_W-1:0] n_rolling;
    logic [dhp_pkg::VALUE_W-1:0] n_cool_one;
    logic [dhp_pkg::VALUE_W-1:0] n_cool_two;
    logic [dhp_pkg::VALUE_W-1:0] n_level;
    logic                        n_dropped;

    logic                        advance;
    logic                        player_two;
    logic [dhp_pkg::VALUE_W-1:0] cool_one_dec;
    logic [dhp_pkg::VALUE_W-1:0] cool_two_dec;
    logic [dhp_pkg::VALUE_W-1:0] cool_sel;
    logic [dhp_pkg::VALUE_W-1:0] hit_inc;
    dhp_pkg::t_fifo_status       st_one;
    dhp_pkg::t_fifo_status       st_two;
    dhp_pkg::t_fifo_status       st_sel;
    logic                        fire;
    logic                        push;
    logic                        pop;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_dropped, r_level};

    assign player_two = r_lane[dhp_pkg::LANE_W-1];
    assign st_sel     = player_two ? st_two : st_one;

    always_comb begin
        cool_one_dec = r_cool_one;
        cool_two_dec = r_cool_two;
        if (r_lane == '0) begin
            if (r_cool_one != '0) cool_one_dec = r_cool_one - 1'b1;
            if (r_cool_two != '0) cool_two_dec = r_cool_two - 1'b1;
        end
        cool_sel = player_two ? cool_two_dec : cool_one_dec;

        fire      = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        n_dropped = 1'b0;
        if (!st_sel.empty) begin
            if (st_sel.front == r_lane && cool_sel == '0) begin
                pop  = 1'b1;
                fire = 1'b1;
            end else if (r_tapped) begin
                push = 1'b1;
            end
        end else if (r_tapped) begin
            if (cool_sel != '0) begin
                push = 1'b1;
            end else begin
                fire = 1'b1;
            end
        end
        if (push && st_sel.full) begin
            n_dropped = 1'b1;
        end

        hit_inc = r_rolling + 1'b1;
        if (hit_inc >= r_hit_ceiling) begin
            hit_inc = r_hit_floor;
        end

        n_cool_one = cool_one_dec;
        n_cool_two = cool_two_dec;
        n_rolling  = r_rolling;
        n_level    = '0;
        if (fire) begin
            n_rolling = hit_inc;
            n_level   = hit_inc;
            if (player_two) begin
                n_cool_two = r_cool_period;
            end else begin
                n_cool_one = r_cool_period;
            end
        end

        if (r_analog_mode) begin
            fire       = 1'b0;
            push       = 1'b0;
            pop        = 1'b0;
            n_dropped  = 1'b0;
            n_cool_one = r_cool_one;
            n_cool_two = r_cool_two;
            n_rolling  = r_rolling;
            n_level    = (r_axis > dhp_pkg::ANALOG_THRESHOLD) ? r_axis : '0;
        end
    end

    dhp_fifo u_fifo_one (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (advance && push && !player_two),
        .i_pop    (advance && pop && !player_two),
        .i_lane   (r_lane),
        .o_status (st_one)
    );

    dhp_fifo u_fifo_two (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (advance && push && player_two),
        .i_pop    (advance && pop && player_two),
        .i_lane   (r_lane),
        .o_status (st_two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_analog_mode <= 1'b0;
            r_cool_period <= dhp_pkg::RESET_COOLDOWN;
            r_hit_floor   <= dhp_pkg::RESET_FLOOR;
            r_hit_ceiling <= dhp_pkg::RESET_CEILING;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dhp_pkg::CFG_ANALOG_MODE: r_analog_mode <= i_cfg_data[0];
                dhp_pkg::CFG_COOLDOWN:    r_cool_period <= i_cfg_data;
                dhp_pkg::CFG_HIT_FLOOR:   r_hit_floor   <= i_cfg_data;
                dhp_pkg::CFG_HIT_CEILING: r_hit_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rolling   <= dhp_pkg::RESET_FLOOR;
            r_cool_one  <= '0;
            r_cool_two  <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_rolling   <= n_rolling;
                r_cool_one  <= n_cool_one;
                r_cool_two  <= n_cool_two;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_lane   <= s_axis_tdata[2:0];
            r_tapped <= s_axis_tdata[3];
            r_axis   <= s_axis_tdata[19:4];
        end
        if (advance) begin
            r_level   <= n_level;
            r_dropped <= n_dropped;
        end
    end

endmodule

>>> rtl/core/dhp_checker.sv
// Port-level checks for drum_hit_pacer_top, bound to the top level.
// Depends on drum_hit_pacer_top.
module dhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_drop_no_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("dropped tap carries a level");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("result padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && o_cfg_ready)
        else $error("output valid after reset");

endmodule

bind drum_hit_pacer_top dhp_checker u_dhp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .o_cfg_ready   (o_cfg_ready)
);
